// File: hdl/mee_pkg.sv
package mee_pkg;

	// Field widths of the escape-time unit.
	localparam int COORD_W = 32;
	localparam int PROD_W  = 64;
	localparam int STEP_W  = 16;
	localparam int EPS_W   = 19;
	localparam int LEVEL_W = 8;
	localparam int CFG_W   = 19;

	// Dividend of the intensity division, step count times 255.
	localparam int DIVIDEND_W = STEP_W + LEVEL_W;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_MAX_ITER = 1'b0,
		CFG_EPS      = 1'b1
	} cfg_reg_t;

	// Iteration sequencer states.
	typedef enum logic [2:0] {
		IT_IDLE,
		IT_SQX,
		IT_SQY,
		IT_MXY,
		IT_UPD,
		IT_DONE
	} iter_state_t;

	// Divider states.
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_HOLD
	} div_state_t;

	// Iteration result handed to the divider.
	typedef struct packed {
		logic              done;
		logic [STEP_W-1:0] steps;
	} iter_res_t;

	// Finished item waiting for the output register.
	typedef struct packed {
		logic               valid;
		logic [STEP_W-1:0]  steps;
		logic [LEVEL_W-1:0] level;
	} div_res_t;

	// Clamp a wide signed value to the signed coordinate range.
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - PROD_W'(1);
		if (v > hi) begin
			sat_coord = hi[COORD_W-1:0];
		end else if (v < lo) begin
			sat_coord = lo[COORD_W-1:0];
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction

	// Absolute difference of two coordinates, one bit wider than they are.
	function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		abs_diff = d[COORD_W] ? $unsigned(-d) : $unsigned(d);
	endfunction

endpackage

// File: hdl/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time unit with a periodicity check. Each item carries a
// point c, a starting z and the number of steps already taken, all coordinates
// in signed Q4.28 (FRAC_BITS fraction bits). The unit iterates z = z*z + c and
// returns the step at which |z|^2 reaches 4, or max_iterations when the limit
// is reached or z settles within converge_eps of a snapshot that is refreshed
// every PERIOD_INTERVAL+1 steps, together with red_level = step_count*255 /
// max_iterations. One item is processed at a time: a single 32x32 multiplier
// is shared by the three products of a step, and the intensity comes from a
// restoring divider. The next item is accepted once the result of the last
// sits in the output register.
// Registers: index 0 max_iterations (reset 256), index 1 converge_eps (reset
// 268435); write them only while no item is in flight.
module mandelbrot_escape_time_top #(
	parameter int PERIOD_INTERVAL = 20,
	parameter int FRAC_BITS       = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [mee_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mee_pkg::COORD_W-1:0]   start_re,
	input  logic signed [mee_pkg::COORD_W-1:0]   start_im,
	input  logic signed [mee_pkg::COORD_W-1:0]   point_re,
	input  logic signed [mee_pkg::COORD_W-1:0]   point_im,
	input  logic        [mee_pkg::STEP_W-1:0]    start_step,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [mee_pkg::STEP_W-1:0]    step_count,
	output logic        [mee_pkg::LEVEL_W-1:0]   red_level
);
	import mee_pkg::*;

	logic [STEP_W-1:0] max_iter_q;
	logic [EPS_W-1:0]  eps_q;
	logic              busy_q;
	logic              out_valid_q;
	logic              in_take;
	logic              out_load;
	iter_res_t         iter_res;
	div_res_t          div_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= STEP_W'(256);
			eps_q      <= EPS_W'(268435);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ITER: max_iter_q <= cfg_data[STEP_W-1:0];
				CFG_EPS:      eps_q      <= cfg_data[EPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_take  = in_valid && !busy_q;
	assign in_stall = busy_q;
	// The finished item moves on when the output register is free or emptying.
	assign out_load = div_res.valid && (!out_valid_q || !out_stall);

	// Busy from acceptance until the result reaches the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_take) begin
			busy_q <= 1'b1;
		end else if (out_load) begin
			busy_q <= 1'b0;
		end
	end

	mee_iter #(
		.FRAC_BITS       (FRAC_BITS),
		.PERIOD_INTERVAL (PERIOD_INTERVAL)
	) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_take),
		.start_re   (start_re),
		.start_im   (start_im),
		.point_re   (point_re),
		.point_im   (point_im),
		.start_step (start_step),
		.limit      (max_iter_q),
		.eps        (eps_q),
		.res        (iter_res)
	);

	mee_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (iter_res.done),
		.steps  (iter_res.steps),
		.limit  (max_iter_q),
		.take   (out_load),
		.res    (div_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			step_count <= div_res.steps;
			red_level  <= div_res.level;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// An accepted item blocks the input until its result is registered.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input not blocked after an item was accepted");

	// A result waiting in the divider always belongs to an item in flight.
	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.valid |-> busy_q)
		else $error("divider holds a result with no item in flight");

	// The iteration never finishes while the divider still holds a result.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		iter_res.done |-> !div_res.valid)
		else $error("iteration finished while the divider was occupied");
`endif

endmodule

// File: hdl/mee_iter.sv
module mee_iter #(
	parameter int FRAC_BITS       = 28,
	parameter int PERIOD_INTERVAL = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [mee_pkg::COORD_W-1:0]   start_re,
	input  logic signed [mee_pkg::COORD_W-1:0]   start_im,
	input  logic signed [mee_pkg::COORD_W-1:0]   point_re,
	input  logic signed [mee_pkg::COORD_W-1:0]   point_im,
	input  logic        [mee_pkg::STEP_W-1:0]    start_step,
	input  logic        [mee_pkg::STEP_W-1:0]    limit,
	input  logic        [mee_pkg::EPS_W-1:0]     eps,
	output mee_pkg::iter_res_t                   res
);
	import mee_pkg::*;

	localparam int PW = $clog2(PERIOD_INTERVAL + 1);
	localparam logic [PW-1:0] PERIOD_LAST = PW'(PERIOD_INTERVAL);
	// The escape bound 4 scaled to the square format; it only exists below 64 bits.
	localparam bit ESC_EN = (2 * FRAC_BITS + 2) < PROD_W;
	localparam logic [PROD_W-1:0] ESC_LIMIT = ESC_EN ? (PROD_W'(1) << (2 * FRAC_BITS + 2)) : '0;

	iter_state_t state_q, state_d;

	logic signed [COORD_W-1:0] zx_q, zy_q, cx_q, cy_q, ox_q, oy_q;
	logic        [STEP_W-1:0]  i_q, steps_q;
	logic        [PW-1:0]      period_q;
	logic                      stepped_q;
	logic        [PROD_W-1:0]  sx_q, sy_q;
	logic signed [PROD_W-1:0]  prod_q;

	logic signed [COORD_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      conv, at_limit, escape;
	logic        [PROD_W-1:0]  mag_sum;
	logic signed [PROD_W-1:0]  nx_w, ny_w;

	// Shared multiplier; its operands follow the sequencer phase.
	always_comb begin
		case (state_q)
			IT_SQY: begin
				mul_a = zy_q;
				mul_b = zy_q;
			end
			IT_MXY: begin
				mul_a = zx_q;
				mul_b = zy_q;
			end
			default: begin
				mul_a = zx_q;
				mul_b = zx_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Tests on the current z: convergence against the snapshot, limit and escape.
	assign conv = (abs_diff(zx_q, ox_q) < (COORD_W+1)'(eps))
		&& (abs_diff(zy_q, oy_q) < (COORD_W+1)'(eps));
	assign at_limit = (i_q >= limit);
	assign mag_sum  = sx_q + $unsigned(prod_q);
	assign escape   = ESC_EN && (mag_sum >= ESC_LIMIT);

	// Next z, floored to the coordinate scale, offset by c.
	assign nx_w = (($signed(sx_q) - $signed(sy_q)) >>> FRAC_BITS) + PROD_W'(cx_q);
	assign ny_w = (prod_q >>> (FRAC_BITS - 1)) + PROD_W'(cy_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result strobe.
	always_comb begin
		state_d   = state_q;
		res.done  = 1'b0;
		res.steps = steps_q;
		case (state_q)
			IT_IDLE: begin
				if (start) begin
					state_d = IT_SQX;
				end
			end
			IT_SQX: begin
				if ((stepped_q && conv) || at_limit) begin
					state_d = IT_DONE;
				end else begin
					state_d = IT_SQY;
				end
			end
			IT_SQY: begin
				state_d = IT_MXY;
			end
			IT_MXY: begin
				state_d = escape ? IT_DONE : IT_UPD;
			end
			IT_UPD: begin
				state_d = IT_SQX;
			end
			IT_DONE: begin
				res.done = 1'b1;
				state_d  = IT_IDLE;
			end
			default: begin
				state_d = IT_IDLE;
			end
		endcase
	end

	// Step, period, stepped flag and result step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			period_q  <= '0;
			stepped_q <= 1'b0;
			steps_q   <= '0;
		end else begin
			case (state_q)
				IT_IDLE: begin
					if (start) begin
						i_q       <= start_step;
						period_q  <= '0;
						stepped_q <= 1'b0;
					end
				end
				IT_SQX: begin
					if ((stepped_q && conv) || at_limit) begin
						steps_q <= limit;
					end else if (stepped_q) begin
						period_q <= (period_q == PERIOD_LAST) ? '0 : period_q + PW'(1);
					end
				end
				IT_MXY: begin
					if (escape) begin
						steps_q <= i_q;
					end
				end
				IT_UPD: begin
					i_q       <= i_q + STEP_W'(1);
					stepped_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Coordinate and product registers.
	always_ff @(posedge clk) begin
		case (state_q)
			IT_IDLE: begin
				if (start) begin
					zx_q <= start_re;
					zy_q <= start_im;
					ox_q <= start_re;
					oy_q <= start_im;
					cx_q <= point_re;
					cy_q <= point_im;
				end
			end
			IT_SQX: begin
				prod_q <= mul_p;
				// Refresh the snapshot once a full period has passed.
				if (stepped_q && !conv && (period_q == PERIOD_LAST)) begin
					ox_q <= zx_q;
					oy_q <= zy_q;
				end
			end
			IT_SQY: begin
				sx_q   <= $unsigned(prod_q);
				prod_q <= mul_p;
			end
			IT_MXY: begin
				sy_q   <= $unsigned(prod_q);
				prod_q <= mul_p;
			end
			IT_UPD: begin
				zx_q <= sat_coord(nx_w);
				zy_q <= sat_coord(ny_w);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/mee_div.sv
module mee_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mee_pkg::STEP_W-1:0]        steps,
	input  logic [mee_pkg::STEP_W-1:0]        limit,
	input  logic                              take,
	output mee_pkg::div_res_t                 res
);
	import mee_pkg::*;

	localparam int CNT_W = $clog2(LEVEL_W);

	div_state_t state_q, state_d;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-2:0] dsh_q;
	logic [LEVEL_W-1:0]    quo_q;
	logic [STEP_W-1:0]     steps_q;
	logic                  zero_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  fits;

	// One restoring step: does the shifted divisor fit in the remainder?
	assign fits = (rem_q >= DIVIDEND_W'(dsh_q));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result.
	always_comb begin
		state_d   = state_q;
		res.valid = 1'b0;
		res.steps = steps_q;
		res.level = zero_q ? '0 : quo_q;
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					state_d = DV_RUN;
				end
			end
			DV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DV_HOLD;
				end
			end
			DV_HOLD: begin
				res.valid = 1'b1;
				if (take) begin
					state_d = DV_IDLE;
				end
			end
			default: begin
				state_d = DV_IDLE;
			end
		endcase
	end

	// Count of quotient bits still to produce, less one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == DV_IDLE && start) begin
			cnt_q <= CNT_W'(LEVEL_W - 1);
		end else if (state_q == DV_RUN) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Quotient bits come out most significant first.
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			rem_q   <= {steps, LEVEL_W'(0)} - DIVIDEND_W'(steps);
			dsh_q   <= {limit, (LEVEL_W-1)'(0)};
			steps_q <= steps;
			zero_q  <= (limit == '0);
		end else if (state_q == DV_RUN) begin
			if (fits) begin
				rem_q <= rem_q - DIVIDEND_W'(dsh_q);
			end
			quo_q <= {quo_q[LEVEL_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// File: test/mandelbrot_escape_time_checker.sv
module mandelbrot_escape_time_checker #(
	parameter int PERIOD_INTERVAL = 20,
	parameter int FRAC_BITS       = 28
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [0:0]                             cfg_index,
	input  logic [mee_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic signed [mee_pkg::COORD_W-1:0]     start_re,
	input  logic signed [mee_pkg::COORD_W-1:0]     start_im,
	input  logic signed [mee_pkg::COORD_W-1:0]     point_re,
	input  logic signed [mee_pkg::COORD_W-1:0]     point_im,
	input  logic        [mee_pkg::STEP_W-1:0]      start_step,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic        [mee_pkg::STEP_W-1:0]      step_count,
	input  logic        [mee_pkg::LEVEL_W-1:0]     red_level,
	output int                                     fail_count,
	output int                                     pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import mee_pkg::*;

	// Escape happens once x*x + y*y reaches 4 at the scale of the squares.
	localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam longint unsigned ESC_BOUND = (ESC_SHIFT < 64) ? (64'd1 << ESC_SHIFT) : 64'd0;
	localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	typedef struct {
		logic [STEP_W-1:0]  steps;
		logic [LEVEL_W-1:0] level;
	} escape_result_t;

	logic [STEP_W-1:0] iter_limit;
	logic [EPS_W-1:0]  conv_eps;
	escape_result_t    expected_q[$];
	escape_result_t    head;
	int                bad;

	// Saturate a wide coordinate to the signed coordinate range.
	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end else if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	// Run the escape-time iteration for one item and work out its result.
	function automatic escape_result_t predict_escape(
			input logic signed [COORD_W-1:0] zr, zi, cr, ci,
			input logic [STEP_W-1:0] first_step, limit,
			input logic [EPS_W-1:0] eps);
		longint x, y, ny, snap_x, snap_y, dx, dy, tol;
		longint unsigned sx, sy;
		int unsigned step, steps;
		int period;
		bit finished;
		escape_result_t r;
		x = zr;
		y = zi;
		snap_x = x;
		snap_y = y;
		tol = longint'(eps);
		step = first_step;
		steps = limit;
		period = 0;
		finished = 1'b0;
		while (!finished && step < limit) begin
			sx = x * x;
			sy = y * y;
			if (ESC_SHIFT < 64 && sx + sy >= ESC_BOUND) begin
				steps = step;
				finished = 1'b1;
			end else begin
				// New z, both parts floored and then saturated.
				ny = clamp_coord(((x * y) >>> (FRAC_BITS - 1)) + ci);
				x = clamp_coord(((longint'(sx) - longint'(sy)) >>> FRAC_BITS) + cr);
				y = ny;
				dx = x - snap_x;
				dy = y - snap_y;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				if (dx < tol && dy < tol) begin
					steps = limit;
					finished = 1'b1;
				end else begin
					// Refresh the snapshot every PERIOD_INTERVAL+1 steps.
					period++;
					if (period > PERIOD_INTERVAL) begin
						period = 0;
						snap_x = x;
						snap_y = y;
					end
					step++;
				end
			end
		end
		r.steps = steps[STEP_W-1:0];
		r.level = (limit == 0) ? '0 : LEVEL_W'((steps * 255) / limit);
		return r;
	endfunction

	// Track the registers, predict accepted items and check accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit <= STEP_W'(256);
			conv_eps <= EPS_W'(268435);
			expected_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_ITER: iter_limit <= cfg_data[STEP_W-1:0];
					CFG_EPS:      conv_eps <= cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_q.push_back(predict_escape(start_re, start_im, point_re, point_im,
					start_step, iter_limit, conv_eps));
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result item with no item waiting: step_count %0d red_level %0d",
						step_count, red_level);
					bad++;
				end else begin
					head = expected_q.pop_front();
					if (step_count !== head.steps) begin
						$error("step_count: expected %0d, actual %0d", head.steps, step_count);
						bad++;
					end
					if (red_level !== head.level) begin
						$error("red_level: expected %0d, actual %0d", head.level, red_level);
						bad++;
					end
				end
			end
			fail_count <= fail_count + bad;
			pending_count <= expected_q.size();
		end
	end

endmodule

// File: test/mandelbrot_escape_time_top_tb.sv
module mandelbrot_escape_time_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mee_pkg::*;

	localparam int PERIOD_INTERVAL = 20;
	localparam int FRAC_BITS       = 28;
	localparam int ONE             = 1 << FRAC_BITS;
	localparam int C_MAX           = 32'h7FFF_FFFF;
	localparam int C_MIN           = 32'h8000_0000;
	localparam int PHASES          = 13;
	localparam int PHASE_ITEMS     = 88;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_re;
		logic signed [COORD_W-1:0] start_im;
		logic signed [COORD_W-1:0] point_re;
		logic signed [COORD_W-1:0] point_im;
		logic        [STEP_W-1:0]  start_step;
	} point_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [0:0]                cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] start_re;
	logic signed [COORD_W-1:0] start_im;
	logic signed [COORD_W-1:0] point_re;
	logic signed [COORD_W-1:0] point_im;
	logic        [STEP_W-1:0]  start_step;
	logic                      out_valid;
	logic                      out_stall;
	logic        [STEP_W-1:0]  step_count;
	logic        [LEVEL_W-1:0] red_level;
	int                        fail_count;
	int                        pending_count;
	bit                        calm = 1'b0;

	int unsigned phase_limits [0:PHASES-1] = '{16, 1, 64, 0, 256, 65535, 8, 32, 128, 2, 100,
		48, 24};

	always #10 clk = ~clk;

	mandelbrot_escape_time_top #(
		.PERIOD_INTERVAL(PERIOD_INTERVAL),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_re(start_re),
		.start_im(start_im),
		.point_re(point_re),
		.point_im(point_im),
		.start_step(start_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.step_count(step_count),
		.red_level(red_level)
	);

	mandelbrot_escape_time_checker #(
		.PERIOD_INTERVAL(PERIOD_INTERVAL),
		.FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_re(start_re),
		.start_im(start_im),
		.point_re(point_re),
		.point_im(point_im),
		.start_step(start_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.step_count(step_count),
		.red_level(red_level),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// Idle cycles before the next item on either side; none during calm phases.
	function automatic int idle_gap();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic point_item_t point(input int zr, zi, cr, ci, input int unsigned first);
		point_item_t p;
		p.start_re = zr;
		p.start_im = zi;
		p.point_re = cr;
		p.point_im = ci;
		p.start_step = first[STEP_W-1:0];
		return p;
	endfunction

	// Random item shaped for the given limit. Mostly points around the set, some
	// points deep inside it, some resumed orbits, and some noise that saturates.
	function automatic point_item_t random_point(input int unsigned limit);
		point_item_t p;
		int unsigned lo;
		int kind;
		kind = $urandom_range(0, 99);
		lo = (limit > 1024) ? limit - 64 : 0;
		p.start_re = '0;
		p.start_im = '0;
		p.point_re = int'($urandom_range(0, 3 * ONE)) - (9 * (ONE / 4));
		p.point_im = int'($urandom_range(0, 3 * ONE)) - (3 * ONE / 2);
		if (kind >= 45 && kind < 65) begin
			p.point_re = int'($urandom_range(0, ONE)) - (3 * ONE / 4);
			p.point_im = int'($urandom_range(0, ONE)) - (ONE / 2);
			p.start_re = int'($urandom_range(0, ONE / 2)) - (ONE / 4);
			p.start_im = int'($urandom_range(0, ONE / 2)) - (ONE / 4);
		end else if (kind >= 65 && kind < 75) begin
			p.start_re = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
			p.start_im = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
		end else if (kind >= 75 && kind < 85) begin
			p.start_re = int'($urandom_range(0, 2 * ONE)) - ONE;
			p.start_im = int'($urandom_range(0, 2 * ONE)) - ONE;
			p.point_re = $urandom;
			p.point_im = $urandom;
		end else if (kind >= 85) begin
			p.start_re = $urandom;
			p.start_im = $urandom;
			p.point_re = $urandom;
			p.point_im = $urandom;
		end
		if ($urandom_range(0, 9) < 7) begin
			p.start_step = STEP_W'($urandom_range(lo, limit));
		end else begin
			p.start_step = STEP_W'($urandom_range(lo, 16'hFFFF));
		end
		return p;
	endfunction

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_point(input point_item_t p);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_re <= p.start_re;
		start_im <= p.start_im;
		point_re <= p.point_re;
		point_im <= p.point_im;
		start_step <= p.start_step;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering items and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers are written with the block idle. The spare high bits of
	// the limit write carry random data that the block must ignore.
	task automatic set_config(input logic [STEP_W-1:0] limit, input logic [EPS_W-1:0] eps);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_ITER;
		cfg_data <= {(CFG_W - STEP_W)'($urandom), limit};
		@(posedge clk);
		cfg_index <= CFG_EPS;
		cfg_data <= CFG_W'(eps);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: stall for a random number of cycles before each result.
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog for a hung block.
	initial begin
		#30000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [EPS_W-1:0] eps;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_ITER;
		cfg_data = '0;
		in_valid = 1'b0;
		start_re = '0;
		start_im = '0;
		point_re = '0;
		point_im = '0;
		start_step = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items with the reset registers: fixed point at the origin,
		// escape exactly at |z|^2 = 4, fast escape, field extremes, saturation
		// both ways, a start step at and just below the limit, a period-two
		// orbit, a slow escape and a point inside the set.
		send_point(point(0, 0, 0, 0, 0));
		send_point(point(0, 0, -2 * ONE, 0, 0));
		send_point(point(0, 0, ONE, ONE, 0));
		send_point(point(C_MAX, C_MAX, C_MAX, C_MAX, 16'hFFFF));
		send_point(point(C_MIN, C_MIN, C_MIN, C_MIN, 0));
		send_point(point(0, 0, C_MAX, C_MAX, 0));
		send_point(point(510027366, 0, C_MAX, 0, 0));
		send_point(point(510027366, -26843546, C_MIN, C_MIN, 0));
		send_point(point(0, 0, -ONE, 0, 255));
		send_point(point(0, 0, -ONE, 0, 256));
		send_point(point(0, 0, -ONE, 0, 0));
		send_point(point(0, 0, 69793219, 0, 0));
		send_point(point(0, 0, -26843546, 174483046, 0));

		// Zero limit gives zero for both fields.
		set_config(16'd0, 19'd268435);
		send_point(point(0, 0, 0, 0, 0));
		send_point(point(0, 0, ONE, ONE, 100));

		// Limit of one with convergence switched off.
		set_config(16'd1, 19'd0);
		send_point(point(0, 0, 0, 0, 0));
		send_point(point(0, 0, -2 * ONE, 0, 0));

		// Largest limit, reached only through a late start step or escape.
		set_config(16'hFFFF, 19'd268435);
		send_point(point(0, 0, ONE, ONE, 0));
		send_point(point(0, 0, 0, 0, 65534));
		send_point(point(0, 0, 69793219, 0, 65000));

		// Widest threshold, then a bounded orbit with no convergence.
		set_config(16'd300, 19'h7FFFF);
		send_point(point(0, 0, -ONE / 2, 0, 0));
		set_config(16'd200, 19'd0);
		send_point(point(0, 0, -201326592, 26843546, 0));

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 5)
				0: eps = 19'd268435;
				1: eps = 19'd0;
				2: eps = 19'h7FFFF;
				3: eps = EPS_W'($urandom_range(1, 64));
				default: eps = EPS_W'($urandom_range(0, 268435));
			endcase
			set_config(phase_limits[ph][STEP_W-1:0], eps);
			calm = (ph % 4 == 3);
			repeat (PHASE_ITEMS) send_point(random_point(phase_limits[ph]));
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/mee_pkg.sv
hdl/mee_iter.sv
hdl/mee_div.sv
hdl/mandelbrot_escape_time_top.sv
test/mandelbrot_escape_time_checker.sv
test/mandelbrot_escape_time_top_tb.sv
